@@ src/civil_datetime_to_ticks_macros.svh @@
// ----------------------------------------------------------------------------
// civil_datetime_to_ticks_macros.svh
// Assertion shorthands for the date/time to tick converter checks.
// ----------------------------------------------------------------------------
`ifndef CIVIL_DATETIME_TO_TICKS_MACROS_SVH
`define CIVIL_DATETIME_TO_TICKS_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst
`define CDT_ASSERT_IMPL(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (cons)) \
    else $error("check failed");

// Next-cycle implication, sampled on clk, off during rst
`define CDT_ASSERT_NEXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (cons)) \
    else $error("check failed");

`endif

@@ src/cdt_pkg.sv @@
// ----------------------------------------------------------------------------
// cdt_pkg
// Field widths, register codes and calendar tables for the date/time to
// tick converter.
// ----------------------------------------------------------------------------
package cdt_pkg;

  // Default tick length in nanoseconds
  localparam int unsigned NS_PER_TICK_DEF = 100;

  // Request field widths
  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 6;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int SEC_W   = 6;
  localparam int NANOS_W = 30;
  localparam int TICKS_W = 62;

  // Stream widths (whole bytes)
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 64;

  // Internal widths
  localparam int CYC_W   = 6;   // full 400-year cycles, at most 40
  localparam int PRIOR_W = 9;   // year within cycle minus one, 0..399
  localparam int DOY_W   = 18;  // day within cycle, below 146097
  localparam int DAYS_W  = 23;  // total day count
  localparam int SECS_W  = 17;  // second of day (wide enough for bad hours)

  // Configuration register codes
  localparam logic [0:0] REG_YEAR_MIN = 1'b0;
  localparam logic [0:0] REG_YEAR_MAX = 1'b1;
  localparam logic [YEAR_W-1:0] YEAR_MIN_RST = 14'd1;
  localparam logic [YEAR_W-1:0] YEAR_MAX_RST = 14'd9999;

  // Calendar constants
  localparam int unsigned DAYS_PER_CYCLE  = 146097;
  localparam int unsigned YEARS_PER_CYCLE = 400;
  // y / 400 == (y * 5243) >> 21 for every 14-bit y
  localparam int unsigned DIV400_MUL   = 5243;
  localparam int          DIV400_SHIFT = 21;
  localparam int unsigned NS_PER_SEC   = 1000000000;

  // Days before the first of the month, common year
  function automatic logic [8:0] days_before_month(input logic [MONTH_W-1:0] month);
    logic [8:0] d;
    begin
      unique case (month)
        4'd1:    d = 9'd0;
        4'd2:    d = 9'd31;
        4'd3:    d = 9'd59;
        4'd4:    d = 9'd90;
        4'd5:    d = 9'd120;
        4'd6:    d = 9'd151;
        4'd7:    d = 9'd181;
        4'd8:    d = 9'd212;
        4'd9:    d = 9'd243;
        4'd10:   d = 9'd273;
        4'd11:   d = 9'd304;
        4'd12:   d = 9'd334;
        default: d = 9'd0;
      endcase
      return d;
    end
  endfunction

  // Month length, common year
  function automatic logic [4:0] month_length(input logic [MONTH_W-1:0] month);
    logic [4:0] n;
    begin
      unique case (month)
        4'd2:                       n = 5'd28;
        4'd4, 4'd6, 4'd9, 4'd11:    n = 5'd30;
        4'd1, 4'd3, 4'd5, 4'd7,
        4'd8, 4'd10, 4'd12:         n = 5'd31;
        default:                    n = 5'd0;
      endcase
      return n;
    end
  endfunction

endpackage

@@ src/civil_datetime_to_ticks.sv @@
// ----------------------------------------------------------------------------
// civil_datetime_to_ticks
// Proleptic Gregorian date and time to tick count since 0001-01-01 00:00.
// ----------------------------------------------------------------------------
//  channel   dir  signals                      payload
//  s_*       in   s_tvalid s_tready s_tdata    year month day hour min sec ns
//  m_*       out  m_tvalid m_tready m_tdata    ticks, m_tuser = valid_res
//  cfg_*     in   cfg_we cfg_index cfg_data    year_min / year_max
//
//  Six register stages; a request is carried through stages 1 to 6 in
//  order and stage 6 drives m_*; one request can be taken every cycle
//  while m_tready is high.
//  The stages follow the multiply chain: y/400, cycle days, ns/tick
//  reciprocal and correction, then the 23 x 40 bit day-to-tick product.
//  Every stage holds its own valid bit and only stalls when the stage
//  after it is full and stalled; bubbles close up under m_tready low.
//  rst clears all valid bits and reloads the year limits.
// ----------------------------------------------------------------------------
module civil_datetime_to_ticks #(
  parameter int unsigned NS_PER_TICK = cdt_pkg::NS_PER_TICK_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // year[13:0] month[17:14] day[23:18] hour[28:24] minute[34:29]
  // second[40:35] nanos[70:41], zero pad [71]
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [cdt_pkg::IN_TDATA_W-1:0]      s_tdata,
  // ticks[61:0], zero pad [63:62]
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [cdt_pkg::OUT_TDATA_W-1:0]     m_tdata,
  // valid_res[0]
  output logic [0:0]                          m_tuser,
  input  logic                                cfg_we,
  input  logic [0:0]                          cfg_index,
  input  logic [cdt_pkg::YEAR_W-1:0]          cfg_data
);

  // Tick scaling, worked out at elaboration
  localparam longint unsigned TPS      = 64'd1000000000 / NS_PER_TICK;
  localparam longint unsigned TPD      = 64'd86400 * TPS;
  localparam int              TPS_W    = $clog2(TPS + 1);
  localparam int              TPD_W    = $clog2(TPD + 1);
  localparam int              TPD_LO_W = (TPD_W > 24) ? 24 : TPD_W;
  localparam int              TPD_HI_W = (TPD_W > 24) ? (TPD_W - 24) : 1;
  localparam longint unsigned RCP      = (64'd1 << 32) / NS_PER_TICK;
  localparam int              RCP_W    = $clog2(RCP + 1);
  localparam int              Q_W      = $clog2(((64'd1 << 30) - 1) / NS_PER_TICK + 1);
  localparam int              NP_W     = cdt_pkg::NANOS_W + RCP_W;
  localparam int              QD_W     = Q_W + cdt_pkg::NANOS_W;
  localparam int              STK_W    = cdt_pkg::SECS_W + TPS_W;
  localparam int              SUB_W    = STK_W + 1;
  localparam int              Y4_W     = 27;

  localparam logic [TPS_W-1:0]           TPS_C    = TPS_W'(TPS);
  localparam logic [TPD_LO_W-1:0]        TPD_LO   = TPD_LO_W'(TPD);
  localparam logic [TPD_HI_W-1:0]        TPD_HI   = TPD_HI_W'(TPD >> TPD_LO_W);
  localparam logic [RCP_W-1:0]           RCP_C    = RCP_W'(RCP);
  localparam logic [cdt_pkg::NANOS_W-1:0] NS_C    = cdt_pkg::NANOS_W'(NS_PER_TICK);
  localparam logic [cdt_pkg::NANOS_W-1:0] NS_SEC_C =
    cdt_pkg::NANOS_W'(cdt_pkg::NS_PER_SEC);

  // --------------------------------------------------------------------------
  // Year limit registers
  // --------------------------------------------------------------------------
  logic [cdt_pkg::YEAR_W-1:0] year_min;
  logic [cdt_pkg::YEAR_W-1:0] year_max;

  always_ff @(posedge clk) begin
    if (rst) begin
      year_min <= cdt_pkg::YEAR_MIN_RST;
      year_max <= cdt_pkg::YEAR_MAX_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cdt_pkg::REG_YEAR_MIN: year_min <= cfg_data;
        cdt_pkg::REG_YEAR_MAX: year_max <= cfg_data;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Stage handshake: a stage loads when it is empty or its successor loads
  // --------------------------------------------------------------------------
  logic v1, v2, v3, v4, v5, v6;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

  assign rdy6 = !v6 || m_tready;
  assign rdy5 = !v5 || rdy6;
  assign rdy4 = !v4 || rdy5;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign s_tready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      if (rdy1) v1 <= s_tvalid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy5) v5 <= v4;
      if (rdy6) v6 <= v5;
    end
  end

  // --------------------------------------------------------------------------
  // Request unpack
  // --------------------------------------------------------------------------
  logic [cdt_pkg::YEAR_W-1:0]  in_year;
  logic [cdt_pkg::MONTH_W-1:0] in_month;
  logic [cdt_pkg::DAY_W-1:0]   in_day;
  logic [cdt_pkg::HOUR_W-1:0]  in_hour;
  logic [cdt_pkg::MIN_W-1:0]   in_min;
  logic [cdt_pkg::SEC_W-1:0]   in_sec;
  logic [cdt_pkg::NANOS_W-1:0] in_nanos;

  assign in_year  = s_tdata[13:0];
  assign in_month = s_tdata[17:14];
  assign in_day   = s_tdata[23:18];
  assign in_hour  = s_tdata[28:24];
  assign in_min   = s_tdata[34:29];
  assign in_sec   = s_tdata[40:35];
  assign in_nanos = s_tdata[70:41];

  // --------------------------------------------------------------------------
  // Stage 1: range checks, year / 400, ns times reciprocal
  // --------------------------------------------------------------------------
  logic [cdt_pkg::YEAR_W-1:0]  y0;
  logic [Y4_W-1:0]             y0_prod;
  logic                        in_ok;

  logic                        s1_ok;
  logic [cdt_pkg::YEAR_W-1:0]  s1_y0;
  logic [cdt_pkg::CYC_W-1:0]   s1_cyc;
  logic [cdt_pkg::MONTH_W-1:0] s1_month;
  logic [cdt_pkg::DAY_W-1:0]   s1_day;
  logic [cdt_pkg::HOUR_W-1:0]  s1_hour;
  logic [cdt_pkg::MIN_W-1:0]   s1_min;
  logic [cdt_pkg::SEC_W-1:0]   s1_sec;
  logic [cdt_pkg::NANOS_W-1:0] s1_nanos;
  logic [NP_W-1:0]             s1_nprod;

  assign y0      = in_year - cdt_pkg::YEAR_W'(1);
  assign y0_prod = Y4_W'(y0) * Y4_W'(cdt_pkg::DIV400_MUL);
  assign in_ok   = (in_year != '0) && (in_year >= year_min) && (in_year <= year_max) &&
                   (in_month >= 4'd1) && (in_month <= 4'd12) && (in_day != '0) &&
                   (in_hour < 5'd24) && (in_min < 6'd60) && (in_sec < 6'd60) &&
                   (in_nanos < NS_SEC_C);

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_ok    <= in_ok;
      s1_y0    <= y0;
      s1_cyc   <= cdt_pkg::CYC_W'(y0_prod >> cdt_pkg::DIV400_SHIFT);
      s1_month <= in_month;
      s1_day   <= in_day;
      s1_hour  <= in_hour;
      s1_min   <= in_min;
      s1_sec   <= in_sec;
      s1_nanos <= in_nanos;
      s1_nprod <= NP_W'(in_nanos) * NP_W'(RCP_C);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: year in cycle, cycle days, second of day, quotient estimate
  // --------------------------------------------------------------------------
  logic [cdt_pkg::YEAR_W-1:0]  cyc_years;

  logic                        s2_ok;
  logic [cdt_pkg::PRIOR_W-1:0] s2_prior;
  logic [cdt_pkg::DAYS_W-1:0]  s2_cdays;
  logic [cdt_pkg::MONTH_W-1:0] s2_month;
  logic [cdt_pkg::DAY_W-1:0]   s2_day;
  logic [cdt_pkg::SECS_W-1:0]  s2_secs;
  logic [cdt_pkg::NANOS_W-1:0] s2_nanos;
  logic [Q_W-1:0]              s2_q0;

  assign cyc_years = cdt_pkg::YEAR_W'(s1_cyc) * cdt_pkg::YEAR_W'(cdt_pkg::YEARS_PER_CYCLE);

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_ok    <= s1_ok;
      s2_prior <= cdt_pkg::PRIOR_W'(s1_y0 - cyc_years);
      s2_cdays <= cdt_pkg::DAYS_W'(s1_cyc) * cdt_pkg::DAYS_W'(cdt_pkg::DAYS_PER_CYCLE);
      s2_month <= s1_month;
      s2_day   <= s1_day;
      s2_secs  <= cdt_pkg::SECS_W'(s1_sec) +
                  cdt_pkg::SECS_W'(s1_min) * cdt_pkg::SECS_W'(60) +
                  cdt_pkg::SECS_W'(s1_hour) * cdt_pkg::SECS_W'(3600);
      s2_nanos <= s1_nanos;
      s2_q0    <= Q_W'(s1_nprod >> 32);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: leap year, month length check, day within cycle,
  // quotient back-multiply, seconds to ticks
  // --------------------------------------------------------------------------
  logic [cdt_pkg::PRIOR_W:0]   cy;
  logic                        leap;
  logic [1:0]                  cent;
  logic [5:0]                  mlen;
  logic [cdt_pkg::DOY_W-1:0]   doy;
  logic [QD_W-1:0]             q0d_full;

  logic                        s3_ok;
  logic [cdt_pkg::DOY_W-1:0]   s3_doy;
  logic [cdt_pkg::DAYS_W-1:0]  s3_cdays;
  logic [STK_W-1:0]            s3_sticks;
  logic [cdt_pkg::NANOS_W-1:0] s3_nanos;
  logic [cdt_pkg::NANOS_W-1:0] s3_q0d;
  logic [Q_W-1:0]              s3_q0;

  always_comb begin
    cy   = (cdt_pkg::PRIOR_W + 1)'(s2_prior) + (cdt_pkg::PRIOR_W + 1)'(1);
    // century years inside the cycle are common, year 400 is leap
    leap = (cy[1:0] == 2'b00) && (cy != 10'd100) && (cy != 10'd200) && (cy != 10'd300);
    priority if (s2_prior >= 9'd300) cent = 2'd3;
    else if (s2_prior >= 9'd200)     cent = 2'd2;
    else if (s2_prior >= 9'd100)     cent = 2'd1;
    else                             cent = 2'd0;
    mlen = 6'(cdt_pkg::month_length(s2_month)) +
           6'((leap && (s2_month == 4'd2)) ? 1 : 0);
    doy  = cdt_pkg::DOY_W'(s2_prior) * cdt_pkg::DOY_W'(365) +
           cdt_pkg::DOY_W'(s2_prior >> 2) - cdt_pkg::DOY_W'(cent) +
           cdt_pkg::DOY_W'(cdt_pkg::days_before_month(s2_month)) +
           cdt_pkg::DOY_W'((leap && (s2_month > 4'd2)) ? 1 : 0) +
           cdt_pkg::DOY_W'(s2_day) - cdt_pkg::DOY_W'(1);
    q0d_full = QD_W'(s2_q0) * QD_W'(NS_C);
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_ok     <= s2_ok && (s2_day <= mlen);
      s3_doy    <= doy;
      s3_cdays  <= s2_cdays;
      s3_sticks <= STK_W'(s2_secs) * STK_W'(TPS_C);
      s3_nanos  <= s2_nanos;
      s3_q0d    <= q0d_full[cdt_pkg::NANOS_W-1:0];
      s3_q0     <= s2_q0;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: total days, quotient correction, sub-day ticks
  // --------------------------------------------------------------------------
  logic [cdt_pkg::NANOS_W-1:0] nrem;
  logic [Q_W-1:0]              q;

  logic                        s4_ok;
  logic [cdt_pkg::DAYS_W-1:0]  s4_days;
  logic [SUB_W-1:0]            s4_sub;

  assign nrem = s3_nanos - s3_q0d;
  assign q    = s3_q0 + Q_W'((nrem >= NS_C) ? 1 : 0);

  always_ff @(posedge clk) begin
    if (rdy4) begin
      s4_ok   <= s3_ok;
      s4_days <= s3_cdays + cdt_pkg::DAYS_W'(s3_doy);
      s4_sub  <= SUB_W'(s3_sticks) + SUB_W'(q);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: days times ticks per day, as two partial products
  // --------------------------------------------------------------------------
  logic                               s5_ok;
  logic [cdt_pkg::DAYS_W+TPD_LO_W-1:0] s5_plo;
  logic [cdt_pkg::DAYS_W+TPD_HI_W-1:0] s5_phi;
  logic [SUB_W-1:0]                   s5_sub;

  always_ff @(posedge clk) begin
    if (rdy5) begin
      s5_ok  <= s4_ok;
      s5_plo <= (cdt_pkg::DAYS_W + TPD_LO_W)'(s4_days) *
                (cdt_pkg::DAYS_W + TPD_LO_W)'(TPD_LO);
      s5_phi <= (cdt_pkg::DAYS_W + TPD_HI_W)'(s4_days) *
                (cdt_pkg::DAYS_W + TPD_HI_W)'(TPD_HI);
      s5_sub <= s4_sub;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: final sum into the output register, zero when invalid
  // --------------------------------------------------------------------------
  logic [63:0]                 tick_sum;
  logic [cdt_pkg::TICKS_W-1:0] s6_ticks;
  logic                        s6_valid_res;

  assign tick_sum = (64'(s5_phi) << TPD_LO_W) + 64'(s5_plo) + 64'(s5_sub);

  always_ff @(posedge clk) begin
    if (rdy6) begin
      s6_valid_res <= s5_ok;
      s6_ticks     <= s5_ok ? tick_sum[cdt_pkg::TICKS_W-1:0] : '0;
    end
  end

  assign m_tvalid   = v6;
  assign m_tdata    = cdt_pkg::OUT_TDATA_W'(s6_ticks);
  assign m_tuser[0] = s6_valid_res;

endmodule

@@ src/cdt_checker.sv @@
// ----------------------------------------------------------------------------
// cdt_checker
// Port-level checks for the date/time to tick converter, bound to the top.
// ----------------------------------------------------------------------------
`include "civil_datetime_to_ticks_macros.svh"

module cdt_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [cdt_pkg::OUT_TDATA_W-1:0] m_tdata,
  input logic [0:0]                      m_tuser
);

  // rejected timestamps always come out as zero ticks
  `CDT_ASSERT_IMPL(a_invalid_zero, m_tvalid && !m_tuser[0], m_tdata == '0)

  // pad bits above the tick count stay clear
  `CDT_ASSERT_IMPL(a_pad_zero, m_tvalid, m_tdata[cdt_pkg::OUT_TDATA_W-1:cdt_pkg::TICKS_W] == '0)

  // with the sink ready nothing in the pipe can hold back a new request
  `CDT_ASSERT_IMPL(a_ready_through, m_tready, s_tready)

  // a stalled result stays put
  `CDT_ASSERT_NEXT(a_hold, m_tvalid && !m_tready,
                   m_tvalid && $stable(m_tdata) && $stable(m_tuser))

endmodule

bind civil_datetime_to_ticks cdt_checker u_cdt_checker (.*);

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the date/time to tick converter against a behavioral predictor.
// A short table of edge cases runs first under the reset year limits, then
// random requests (mostly well-formed dates, some with one field broken, some
// raw noise) run under several year-limit settings. Both stream sides idle at
// random; every result is compared with the oldest pending expectation.
// ----------------------------------------------------------------------------
module testbench;
  import cdt_pkg::*;

  localparam int unsigned      TICK_NS       = NS_PER_TICK_DEF;
  localparam longint unsigned  TICKS_PER_SEC = 64'd1000000000 / TICK_NS;
  localparam longint unsigned  TICKS_PER_DAY = 64'd86400 * TICKS_PER_SEC;
  localparam int               PIPE_DEPTH    = 6;
  localparam int               STALL_LIMIT   = 3000;
  localparam int               NUM_PHASES    = 7;

  // year[13:0] month[17:14] day[23:18] hour[28:24] minute[34:29]
  // second[40:35] nanos[70:41], zero pad [71]
  typedef struct packed {
    logic               pad;
    logic [NANOS_W-1:0] nanos;
    logic [SEC_W-1:0]   second;
    logic [MIN_W-1:0]   minute;
    logic [HOUR_W-1:0]  hour;
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
  } stamp_t;

  typedef struct {
    stamp_t             stamp;
    logic [TICKS_W-1:0] ticks;
    logic               ok;
  } tick_due_t;

  typedef struct {
    stamp_t             stamp;
    bit                 typed;
    logic [TICKS_W-1:0] ticks;
    logic               ok;
  } chart_row_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    s_tvalid = 1'b0;
  logic                    s_tready;
  logic [IN_TDATA_W-1:0]   s_tdata = '0;
  logic                    m_tvalid;
  logic                    m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]  m_tdata;
  logic [0:0]              m_tuser;
  logic                    cfg_we = 1'b0;
  logic [0:0]              cfg_index = REG_YEAR_MIN;
  logic [YEAR_W-1:0]       cfg_data = '0;

  // Expectation for the request currently on s_*, moved with the data
  logic [TICKS_W-1:0]      next_ticks = '0;
  logic                    next_ok = 1'b0;

  // Shadow copies of the year limits
  logic [YEAR_W-1:0]       year_lo = YEAR_MIN_RST;
  logic [YEAR_W-1:0]       year_hi = YEAR_MAX_RST;

  int unsigned cum_days [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

  int unsigned ph_lo    [NUM_PHASES] = '{1, 0, 1600, 5000, 16383, 9999, 1};
  int unsigned ph_hi    [NUM_PHASES] = '{9999, 16383, 2400, 4000, 16383, 9999, 1};
  int unsigned ph_items [NUM_PHASES] = '{450, 400, 300, 150, 150, 150, 150};

  tick_due_t   tick_due [$];
  chart_row_t  chart [$];
  int          errors = 0;
  int          idle_cycles = 0;
  int          burst_left = 0;

  civil_datetime_to_ticks dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic bit is_leap(input int unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  // Month length for month 1..12 of year y
  function automatic int unsigned days_in_month(input int unsigned y, input int unsigned m);
    int unsigned n;
    n = ((m == 12) ? 365 : cum_days[m]) - cum_days[m-1];
    if (m == 2 && is_leap(y)) n++;
    return n;
  endfunction

  function automatic void convert_stamp(input stamp_t s, output logic [TICKS_W-1:0] tk,
                                        output logic ok);
    longint unsigned y0;
    longint unsigned days;
    longint unsigned total;
    int unsigned     ml;
    ml = (s.month >= 1 && s.month <= 12) ? days_in_month(s.year, s.month) : 0;
    ok = (s.year != 0) && (s.year >= year_lo) && (s.year <= year_hi) &&
         (s.month >= 1) && (s.month <= 12) && (s.day >= 1) && (s.day <= ml) &&
         (s.hour < 24) && (s.minute < 60) && (s.second < 60) && (s.nanos < NS_PER_SEC);
    tk = '0;
    if (ok) begin
      // whole days since the epoch, leap days counted over all prior years
      y0 = s.year - 1;
      days = y0 * 365 + y0 / 4 - y0 / 100 + y0 / 400 + cum_days[s.month-1] + s.day - 1;
      if (is_leap(s.year) && s.month > 2) days++;
      total = days * TICKS_PER_DAY +
              (s.hour * 3600 + s.minute * 60 + s.second) * TICKS_PER_SEC +
              s.nanos / TICK_NS;
      tk = total[TICKS_W-1:0];
    end
  endfunction

  // ---------------------------------------------------------------- request generators

  // Well-formed date inside the current year limits (any year if they cross)
  function automatic stamp_t make_good();
    stamp_t      s;
    int unsigned lo;
    int unsigned ml;
    s = '0;
    lo = (year_lo == 0) ? 1 : year_lo;
    if (lo <= year_hi) begin
      case ($urandom_range(0, 9))
        0:       s.year = YEAR_W'(lo);
        1:       s.year = year_hi;
        default: s.year = YEAR_W'($urandom_range(lo, year_hi));
      endcase
    end else begin
      s.year = YEAR_W'($urandom_range(1, 16383));
    end
    s.month = MONTH_W'(($urandom_range(0, 7) == 0) ? 2 : $urandom_range(1, 12));
    ml = days_in_month(s.year, s.month);
    case ($urandom_range(0, 9))
      0:       s.day = DAY_W'(ml);
      1:       s.day = DAY_W'(1);
      default: s.day = DAY_W'($urandom_range(1, ml));
    endcase
    s.hour   = HOUR_W'($urandom_range(0, 23));
    s.minute = MIN_W'($urandom_range(0, 59));
    s.second = SEC_W'($urandom_range(0, 59));
    case ($urandom_range(0, 9))
      0:       s.nanos = NANOS_W'(999999999);
      1:       s.nanos = '0;
      default: s.nanos = NANOS_W'($urandom_range(0, 999999999));
    endcase
    return s;
  endfunction

  // Push exactly one field of a good date out of its range
  function automatic stamp_t break_field(input stamp_t s);
    int unsigned ml;
    ml = days_in_month(s.year, s.month);
    case ($urandom_range(0, 7))
      0: s.year = '0;
      1: begin
        if (year_hi < 16383) s.year = YEAR_W'($urandom_range(year_hi + 1, 16383));
        else if (year_lo > 1) s.year = YEAR_W'($urandom_range(1, year_lo - 1));
        else s.year = '0;
      end
      2: s.month  = MONTH_W'($urandom_range(0, 1) ? 0 : $urandom_range(13, 15));
      3: s.day    = DAY_W'($urandom_range(0, 1) ? 0 : $urandom_range(ml + 1, 63));
      4: s.hour   = HOUR_W'($urandom_range(24, 31));
      5: s.minute = MIN_W'($urandom_range(60, 63));
      6: s.second = SEC_W'($urandom_range(60, 63));
      default: s.nanos = NANOS_W'($urandom_range(1000000000, 1073741823));
    endcase
    return s;
  endfunction

  function automatic stamp_t make_noise();
    logic [95:0] raw;
    stamp_t      s;
    raw = {$urandom(), $urandom(), $urandom()};
    s = raw[$bits(stamp_t)-1:0];
    s.pad = 1'b0;
    return s;
  endfunction

  // Idle length: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 85) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 12);
    else return $urandom_range(25, 70);
  endfunction

  // ---------------------------------------------------------------- driving tasks

  task automatic add_row(input int unsigned y, input int unsigned mo, input int unsigned d,
                         input int unsigned h, input int unsigned mi, input int unsigned sc,
                         input int unsigned ns, input bit typed,
                         input longint unsigned tk, input logic ok);
    chart_row_t row;
    row.stamp = '0;
    row.stamp.year   = YEAR_W'(y);
    row.stamp.month  = MONTH_W'(mo);
    row.stamp.day    = DAY_W'(d);
    row.stamp.hour   = HOUR_W'(h);
    row.stamp.minute = MIN_W'(mi);
    row.stamp.second = SEC_W'(sc);
    row.stamp.nanos  = NANOS_W'(ns);
    row.typed = typed;
    row.ticks = TICKS_W'(tk);
    row.ok    = ok;
    chart.push_back(row);
  endtask

  // Present one request and hold it until accepted
  task automatic push_stamp(input stamp_t s, input logic [TICKS_W-1:0] tk, input logic ok);
    int unsigned gap;
    if (burst_left > 0) begin
      gap = 0;
      burst_left--;
    end else begin
      gap = pick_gap();
      if ($urandom_range(0, 49) == 0) burst_left = $urandom_range(20, 60);
    end
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid   <= 1'b1;
    s_tdata    <= s;
    next_ticks <= tk;
    next_ok    <= ok;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Stop sending until every pending result is back, then let the pipe settle
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (tick_due.size() != 0) @(posedge clk);
    repeat (2 * PIPE_DEPTH) @(posedge clk);
  endtask

  task automatic write_limit(input logic [0:0] idx, input logic [YEAR_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == REG_YEAR_MIN) year_lo = val;
    else year_hi = val;
  endtask

  // ---------------------------------------------------------------- result checking

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (tick_due.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("ERROR: unexpected result ticks=%0d valid=%0b", m_tdata, m_tuser);
        end else if (m_tdata !== {{(OUT_TDATA_W-TICKS_W){1'b0}}, tick_due[0].ticks} ||
                     m_tuser[0] !== tick_due[0].ok) begin
          errors++;
          if (errors <= 10)
            $display({"ERROR: %0d-%0d-%0d %0d:%0d:%0d.%0d",
                      " expected ticks=%0d valid=%0b, got ticks=%0d valid=%0b"},
                     tick_due[0].stamp.year, tick_due[0].stamp.month, tick_due[0].stamp.day,
                     tick_due[0].stamp.hour, tick_due[0].stamp.minute, tick_due[0].stamp.second,
                     tick_due[0].stamp.nanos, tick_due[0].ticks, tick_due[0].ok,
                     m_tdata, m_tuser);
          void'(tick_due.pop_front());
        end else begin
          void'(tick_due.pop_front());
        end
      end
      // record the request taken at this edge
      if (s_tvalid && s_tready)
        tick_due.push_back('{stamp: stamp_t'(s_tdata), ticks: next_ticks, ok: next_ok});
    end
  end

  // Watchdog: too long without any handshake on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------- result side stalls

  initial begin : sink
    int unsigned run;
    int unsigned gap;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 12);
      m_tready <= 1'b1;
      repeat (run) @(posedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  initial begin : stimulus
    stamp_t             s;
    logic [TICKS_W-1:0] tk;
    logic               ok;
    int unsigned        r;

    // Directed cases under the reset year limits
    add_row(1, 1, 1, 0, 0, 0, 0, 1, 0, 1'b1);                              // epoch
    add_row(9999, 12, 31, 23, 59, 59, 999999999, 1, 64'd3155378975999999999, 1'b1);
    add_row(0, 1, 1, 0, 0, 0, 0, 1, 0, 1'b0);                              // year zero
    add_row(10000, 1, 1, 0, 0, 0, 0, 1, 0, 1'b0);                          // above limit
    add_row(16383, 15, 63, 31, 63, 63, 1073741823, 1, 0, 1'b0);            // all fields max
    add_row(2020, 0, 10, 1, 1, 1, 1, 1, 0, 1'b0);
    add_row(2020, 13, 10, 1, 1, 1, 1, 1, 0, 1'b0);
    add_row(2020, 15, 10, 1, 1, 1, 1, 1, 0, 1'b0);
    add_row(2020, 5, 0, 1, 1, 1, 1, 1, 0, 1'b0);
    add_row(2020, 1, 32, 1, 1, 1, 1, 1, 0, 1'b0);
    add_row(2020, 1, 63, 1, 1, 1, 1, 1, 0, 1'b0);
    add_row(2021, 4, 31, 1, 1, 1, 1, 1, 0, 1'b0);
    add_row(2000, 2, 29, 6, 7, 8, 9, 0, 0, 1'b0);                          // leap century
    add_row(1900, 2, 29, 0, 0, 0, 0, 1, 0, 1'b0);                          // common century
    add_row(2001, 2, 29, 0, 0, 0, 0, 1, 0, 1'b0);
    add_row(2004, 2, 29, 12, 34, 56, 123456789, 0, 0, 1'b0);
    add_row(2000, 12, 31, 23, 59, 59, 999999999, 0, 0, 1'b0);
    add_row(400, 12, 31, 23, 59, 59, 999999999, 0, 0, 1'b0);               // end of a cycle
    add_row(401, 1, 1, 0, 0, 0, 0, 0, 0, 1'b0);
    add_row(1999, 7, 4, 24, 0, 0, 0, 1, 0, 1'b0);                          // hour twenty-four
    add_row(1999, 7, 4, 31, 0, 0, 0, 1, 0, 1'b0);
    add_row(1999, 7, 4, 0, 63, 0, 0, 1, 0, 1'b0);
    add_row(1999, 7, 4, 0, 0, 60, 0, 1, 0, 1'b0);
    add_row(1999, 7, 4, 0, 0, 0, 1000000000, 1, 0, 1'b0);
    add_row(1999, 7, 4, 0, 0, 0, 1073741823, 1, 0, 1'b0);

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (chart[i]) begin
      if (chart[i].typed) begin
        tk = chart[i].ticks;
        ok = chart[i].ok;
      end else begin
        convert_stamp(chart[i].stamp, tk, ok);
      end
      push_stamp(chart[i].stamp, tk, ok);
    end

    // Random requests under a series of year-limit settings
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) begin
        write_limit(REG_YEAR_MIN, YEAR_W'(ph_lo[p]));
        write_limit(REG_YEAR_MAX, YEAR_W'(ph_hi[p]));
      end
      for (int k = 0; k < ph_items[p]; k++) begin
        r = $urandom_range(0, 99);
        if (r < 70) s = make_good();
        else if (r < 85) s = break_field(make_good());
        else s = make_noise();
        convert_stamp(s, tk, ok);
        push_stamp(s, tk, ok);
        if ($urandom_range(0, 299) == 0) wait_idle();
      end
      wait_idle();
    end

    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+src
src/cdt_pkg.sv
src/civil_datetime_to_ticks.sv
src/cdt_checker.sv
tb/testbench.sv
